@@ rtl/iap_pkg.sv @@
package iap_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef logic [3:0] opcode_t;

  localparam opcode_t OP_ADD = 4'd0;
  localparam opcode_t OP_SUB = 4'd1;
  localparam opcode_t OP_MUL = 4'd2;
  localparam opcode_t OP_DIV = 4'd3;
  localparam opcode_t OP_EQ  = 4'd4;
  localparam opcode_t OP_LT  = 4'd5;
  localparam opcode_t OP_GT  = 4'd6;
  localparam opcode_t OP_LE  = 4'd7;
  localparam opcode_t OP_GE  = 4'd8;
  localparam opcode_t OP_POW = 4'd9;

  typedef logic [1:0] err_t;

  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_DIV_ZERO = 2'd1;
  localparam err_t ERR_NEG_EXP  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_SIGN,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_DONE
  } state_t;

  typedef struct packed {
    opcode_t                       operation;
    logic signed [WORD_BITS-1:0]   operand_a;
    logic signed [WORD_BITS-1:0]   operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0]   result_value;
    err_t                          error_code;
  } out_item_t;

  typedef struct packed {
    logic [WORD_BITS:0]   add_x;
    logic [WORD_BITS:0]   add_y;
    logic                 add_sub;
    logic [WORD_BITS-1:0] mul_x;
    logic [WORD_BITS-1:0] mul_y;
  } unit_req_t;

  typedef struct packed {
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] prod;
  } unit_rsp_t;

endpackage

@@ rtl/iap_unit.sv @@
module iap_unit (
  input  iap_pkg::unit_req_t req,
  output iap_pkg::unit_rsp_t rsp
);
  import iap_pkg::*;

  logic [WORD_BITS:0] y_eff;

  // subtract as add of the inverted operand plus carry in
  assign y_eff    = req.add_sub ? ~req.add_y : req.add_y;
  assign rsp.sum  = req.add_x + y_eff + {{WORD_BITS{1'b0}}, req.add_sub};
  // wrapping product, low word only
  assign rsp.prod = req.mul_x * req.mul_y;

endmodule

@@ rtl/integer_alu_with_power.sv @@
// Integer ALU taking one item at a time: in_ready is high only while the block
// is idle. Add, subtract, multiply and the five comparisons register the
// result on acceptance and go to the final step, which loads the output and
// raises out_valid. Division is restoring, one quotient bit per cycle on the
// shared adder, then a sign step that negates the quotient where needed.
// Power uses square-and-multiply on the single shared 32x32 multiplier: for
// each exponent bit up to the highest set bit, a set bit first multiplies
// the accumulator by the base, and each bit then squares the base; once the
// exponent is zero the accumulator is the result. Divide by zero and
// negative exponents return 0 with an error code, going from idle straight
// to the final step. A result that has not been taken holds the block in its
// final step until out_ready.
module integer_alu_with_power (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  iap_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output iap_pkg::out_item_t out_data
);
  import iap_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  state_t state, state_next;

  logic [WORD_BITS-1:0] rem, rem_next;
  logic [WORD_BITS-1:0] quo, quo_next;
  logic [WORD_BITS-1:0] dvs, dvs_next;
  logic                 neg_q, neg_q_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [WORD_BITS-1:0] acc, acc_next;
  logic [WORD_BITS-1:0] base, base_next;
  logic [WORD_BITS-1:0] expo, expo_next;
  logic [WORD_BITS-1:0] res, res_next;
  err_t                 err, err_next;
  logic                 load_out;

  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  logic [WORD_BITS-1:0] op_a, op_b, mag_a, mag_b;
  logic                 is_eq, is_lt;

  iap_unit u_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  assign op_a     = in_data.operand_a;
  assign op_b     = in_data.operand_b;
  assign mag_a    = op_a[WORD_BITS-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b    = op_b[WORD_BITS-1] ? (~op_b + 1'b1) : op_b;
  assign is_eq    = (op_a == op_b);
  // sign of the widened difference a - b
  assign is_lt    = unit_rsp.sum[WORD_BITS];
  assign in_ready = (state == ST_IDLE);
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            OP_DIV:  state_next = (op_b == '0) ? ST_DONE : ST_DIV;
            OP_POW:  state_next = op_b[WORD_BITS-1] ? ST_DONE : ST_POW_MUL;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_DIV_SIGN;
      end
      ST_DIV_SIGN: state_next = ST_DONE;
      ST_POW_MUL: begin
        if (expo == '0) begin
          state_next = ST_DONE;
        end else if (expo[0]) begin
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_SQR: state_next = ST_POW_MUL;
      ST_DONE: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    unit_req   = '0;
    rem_next   = rem;
    quo_next   = quo;
    dvs_next   = dvs;
    neg_q_next = neg_q;
    cnt_next   = cnt;
    acc_next   = acc;
    base_next  = base;
    expo_next  = expo;
    res_next   = res;
    err_next   = err;
    unique case (state)
      ST_IDLE: begin
        unit_req.add_x   = {op_a[WORD_BITS-1], op_a};
        unit_req.add_y   = {op_b[WORD_BITS-1], op_b};
        unit_req.add_sub = (in_data.operation != OP_ADD);
        unit_req.mul_x   = op_a;
        unit_req.mul_y   = op_b;
        if (in_valid) begin
          res_next = '0;
          err_next = ERR_NONE;
          case (in_data.operation) inside
            OP_ADD, OP_SUB: res_next = unit_rsp.sum[WORD_BITS-1:0];
            OP_MUL:         res_next = unit_rsp.prod;
            OP_EQ:          res_next = {{(WORD_BITS-1){1'b0}}, is_eq};
            OP_LT:          res_next = {{(WORD_BITS-1){1'b0}}, is_lt};
            OP_GT:          res_next = {{(WORD_BITS-1){1'b0}}, !is_lt && !is_eq};
            OP_LE:          res_next = {{(WORD_BITS-1){1'b0}}, is_lt || is_eq};
            OP_GE:          res_next = {{(WORD_BITS-1){1'b0}}, !is_lt};
            OP_DIV: begin
              if (op_b == '0) begin
                err_next = ERR_DIV_ZERO;
              end else begin
                rem_next   = '0;
                quo_next   = mag_a;
                dvs_next   = mag_b;
                neg_q_next = op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
                cnt_next   = CNT_LAST;
              end
            end
            OP_POW: begin
              if (op_b[WORD_BITS-1]) begin
                err_next = ERR_NEG_EXP;
              end else begin
                acc_next  = {{(WORD_BITS-1){1'b0}}, 1'b1};
                base_next = op_a;
                expo_next = op_b;
              end
            end
            default: res_next = '0;
          endcase
        end
      end
      ST_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        unit_req.add_x   = {rem, quo[WORD_BITS-1]};
        unit_req.add_y   = {1'b0, dvs};
        unit_req.add_sub = 1'b1;
        if (!unit_rsp.sum[WORD_BITS]) begin
          rem_next = unit_rsp.sum[WORD_BITS-1:0];
          quo_next = {quo[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_next = {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
          quo_next = {quo[WORD_BITS-2:0], 1'b0};
        end
        cnt_next = cnt - 1'b1;
      end
      ST_DIV_SIGN: begin
        unit_req.add_x   = '0;
        unit_req.add_y   = {1'b0, quo};
        unit_req.add_sub = neg_q;
        res_next         = unit_rsp.sum[WORD_BITS-1:0];
      end
      ST_POW_MUL: begin
        if (expo == '0) begin
          res_next = acc;
        end else if (expo[0]) begin
          unit_req.mul_x = acc;
          unit_req.mul_y = base;
          acc_next       = unit_rsp.prod;
        end else begin
          // exponent bit clear: square straight away
          unit_req.mul_x = base;
          unit_req.mul_y = base;
          base_next      = unit_rsp.prod;
          expo_next      = {1'b0, expo[WORD_BITS-1:1]};
        end
      end
      ST_POW_SQR: begin
        unit_req.mul_x = base;
        unit_req.mul_y = base;
        base_next      = unit_rsp.prod;
        expo_next      = {1'b0, expo[WORD_BITS-1:1]};
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem   <= rem_next;
    quo   <= quo_next;
    dvs   <= dvs_next;
    neg_q <= neg_q_next;
    cnt   <= cnt_next;
    acc   <= acc_next;
    base  <= base_next;
    expo  <= expo_next;
    res   <= res_next;
    err   <= err_next;
    if (load_out) begin
      out_data.result_value <= res;
      out_data.error_code   <= err;
    end
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iap_pkg::*;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t   MOST_NEG     = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t   MOST_POS     = ~MOST_NEG;
  localparam word_t   ALL_ONES     = '1;
  localparam opcode_t OP_LAST_CODE = 4'hF;
  localparam int      DRAIN_CYCLES = 80;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  items_pending[$];
  out_item_t results_due[$];

  logic in_taken     = 1'b0;
  logic send_hold    = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_requests  = 0;
  int   holds_served   = 0;
  int   hold_left      = 0;
  int   mismatches     = 0;
  int   results_checked = 0;
  int   op_seen[16];

  integer_alu_with_power uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic out_item_t alu_result_of(in_item_t item);
    word_t     a;
    word_t     b;
    word_t     mag_a;
    word_t     mag_b;
    word_t     quot;
    word_t     base;
    word_t     expo;
    word_t     acc;
    out_item_t r;
    a    = item.operand_a;
    b    = item.operand_b;
    r.result_value = '0;
    r.error_code   = ERR_NONE;
    case (item.operation)
      OP_ADD: r.result_value = a + b;
      OP_SUB: r.result_value = a - b;
      OP_MUL: r.result_value = a * b;
      OP_DIV: begin
        if (b == '0) begin
          r.error_code = ERR_DIV_ZERO;
        end else begin
          mag_a = a[WORD_BITS-1] ? -a : a;
          mag_b = b[WORD_BITS-1] ? -b : b;
          quot  = mag_a / mag_b;
          if (a[WORD_BITS-1] != b[WORD_BITS-1]) begin
            quot = -quot;
          end
          r.result_value = quot;
        end
      end
      OP_EQ: r.result_value = (a == b) ? 1 : 0;
      OP_LT: r.result_value = ($signed(a) < $signed(b)) ? 1 : 0;
      OP_GT: r.result_value = ($signed(a) > $signed(b)) ? 1 : 0;
      OP_LE: r.result_value = ($signed(a) <= $signed(b)) ? 1 : 0;
      OP_GE: r.result_value = ($signed(a) >= $signed(b)) ? 1 : 0;
      OP_POW: begin
        if (b[WORD_BITS-1]) begin
          r.error_code = ERR_NEG_EXP;
        end else begin
          base = a;
          expo = b;
          acc  = 1;
          for (int i = 0; i < WORD_BITS; i++) begin
            if (expo[0]) begin
              acc = acc * base;
            end
            expo = expo >> 1;
            base = base * base;
          end
          r.result_value = acc;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("error at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // sender: new item only once the previous one has been taken
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (items_pending.size() != 0 && !send_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data  <= items_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off counted here
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= 600;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin : watch_ports
    out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        results_due.push_back(alu_result_of(in_data));
        op_seen[in_data.operation]++;
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %h/%0d",
                                  out_data.result_value, out_data.error_code));
        end else begin
          want = results_due.pop_front();
          if (out_data.result_value !== want.result_value) begin
            flag_mismatch($sformatf("result_value %h, predicted %h",
                                    out_data.result_value, want.result_value));
          end
          if (out_data.error_code !== want.error_code) begin
            flag_mismatch($sformatf("error_code %0d, predicted %0d",
                                    out_data.error_code, want.error_code));
          end
        end
      end
    end
  end

  task automatic queue_item(opcode_t op, word_t a, word_t b);
    in_item_t item;
    item.operation = op;
    item.operand_a = a;
    item.operand_b = b;
    items_pending.push_back(item);
  endtask

  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(5))
      0: v = word_t'($urandom_range(40)) - 20;
      1: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 1;
          2: v = ALL_ONES;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      2: begin
        v = word_t'(1) << $urandom_range(WORD_BITS - 1);
        if ($urandom_range(1) != 0) begin
          v = -v;
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_random(int count);
    opcode_t op;
    word_t   a;
    word_t   b;
    int      pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        op = opcode_t'($urandom_range(int'(OP_POW) + 1, int'(OP_LAST_CODE)));
      end else if (pick < 25) begin
        op = OP_POW;
      end else if (pick < 40) begin
        op = OP_DIV;
      end else begin
        op = opcode_t'($urandom_range(int'(OP_ADD), int'(OP_POW)));
      end
      a = pick_operand();
      b = pick_operand();
      case (op) inside
        OP_POW: begin
          // mostly short exponents, now and then a huge or negative one
          case ($urandom_range(9))
            0: b = $urandom;
            1: b = -word_t'($urandom_range(1, 50));
            default: b = $urandom_range(40);
          endcase
        end
        OP_DIV: if ($urandom_range(15) == 0) begin
          b = '0;
        end
        OP_EQ, OP_LT, OP_GT, OP_LE, OP_GE: if ($urandom_range(3) == 0) begin
          b = a;
        end
        default: ;
      endcase
      queue_item(op, a, b);
    end
  endtask

  task automatic wait_drained();
    while (items_pending.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    queue_item(OP_ADD, MOST_POS, 1);
    queue_item(OP_ADD, MOST_NEG, ALL_ONES);
    queue_item(OP_SUB, MOST_NEG, 1);
    queue_item(OP_SUB, '0, MOST_NEG);
    queue_item(OP_MUL, MOST_POS, MOST_POS);
    queue_item(OP_MUL, MOST_NEG, ALL_ONES);
    queue_item(OP_DIV, 7, -word_t'(2));
    queue_item(OP_DIV, -word_t'(7), 2);
    queue_item(OP_DIV, 12345, '0);
    queue_item(OP_DIV, MOST_NEG, ALL_ONES);
    queue_item(OP_DIV, '0, 5);
    queue_item(OP_EQ, ALL_ONES, ALL_ONES);
    queue_item(OP_EQ, MOST_NEG, MOST_POS);
    queue_item(OP_LT, MOST_NEG, MOST_POS);
    queue_item(OP_GT, MOST_NEG, MOST_POS);
    queue_item(OP_LE, 42, 42);
    queue_item(OP_GE, ALL_ONES, '0);
    queue_item(OP_POW, 3, 5);
    queue_item(OP_POW, '0, '0);
    queue_item(OP_POW, 2, 31);
    queue_item(OP_POW, 3, MOST_POS);
    queue_item(OP_POW, 5, MOST_NEG);
    queue_item(OP_POW, ALL_ONES, ALL_ONES);
    queue_item(opcode_t'(int'(OP_POW) + 1), MOST_POS, MOST_POS);
    queue_item(OP_LAST_CODE, ALL_ONES, ALL_ONES);
    wait_drained();

    // back to back, with one pause until the block has emptied
    queue_random(356);
    while (items_pending.size() > 180) begin
      @(posedge clk);
    end
    send_hold <= 1'b1;
    while (in_valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    send_hold <= 1'b0;
    wait_drained();

    send_idle_pct = 85;
    queue_random(356);
    wait_drained();

    // long hold-off first, with the sender still offering items
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    hold_requests  = hold_requests + 1;
    queue_random(356);
    wait_drained();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    queue_random(356);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results: %0d division, %0d power, %0d unused-code items",
             results_checked, op_seen[OP_DIV], op_seen[OP_POW],
             results_checked - op_seen[OP_ADD] - op_seen[OP_SUB] - op_seen[OP_MUL]
             - op_seen[OP_DIV] - op_seen[OP_EQ] - op_seen[OP_LT] - op_seen[OP_GT]
             - op_seen[OP_LE] - op_seen[OP_GE] - op_seen[OP_POW]);
    $display("%s%s", "phases: directed corners, back to back, slow sender, ",
             "slow receiver with long hold-off, both stalling");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
